// ----- rtl/core/ffds_pkg.sv -----
package ffds_pkg;

  localparam logic [2:0] ACT_LOOKUP = 3'd0;
  localparam logic [2:0] ACT_START  = 3'd1;
  localparam logic [2:0] ACT_DATA   = 3'd2;
  localparam logic [2:0] ACT_END    = 3'd3;
  localparam logic [2:0] ACT_DELETE = 3'd4;
  localparam logic [2:0] ACT_FORMAT = 3'd5;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd1;
  localparam logic [2:0] ST_NO_SPACE   = 3'd2;
  localparam logic [2:0] ST_BAD_SIZE   = 3'd3;
  localparam logic [2:0] ST_OVERFLOW   = 3'd4;
  localparam logic [2:0] ST_INCOMPLETE = 3'd5;
  localparam logic [2:0] ST_DIR_FULL   = 3'd6;

  localparam logic [0:0] CFG_START = 1'd0;
  localparam logic [0:0] CFG_SIZE  = 1'd1;

  localparam logic [23:0] START_RESET = 24'd16384;
  localparam logic [24:0] SIZE_RESET  = 25'd8372224;
  localparam logic [24:0] ADDR_LIMIT  = 25'h1000000;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'h1021;

  typedef struct packed {
    logic [15:0] id;
    logic [23:0] start;
    logic [23:0] size;
    logic [15:0] crc;
  } entry_t;

  typedef struct packed {
    logic accept;
    logic issue;
    logic commit;
  } dp_cmd_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/ffds_ram.sv -----
module ffds_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 128
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/ffds_ctrl.sv -----
module ffds_ctrl #(
  parameter int DIR_ENTRIES = 128
) (
  input  logic                                             clk,
  input  logic                                             rst,
  input  logic                                             in_valid,
  output logic                                             in_ready,
  input  logic [2:0]                                       action,
  output logic                                             out_valid,
  input  logic                                             out_ready,
  output ffds_pkg::dp_cmd_t                                cmd,
  output logic [(DIR_ENTRIES > 1 ? $clog2(DIR_ENTRIES) : 1)-1:0] rd_addr
);

  localparam int AW = DIR_ENTRIES > 1 ? $clog2(DIR_ENTRIES) : 1;
  localparam int CW = AW + 1;

  typedef enum logic [3:0] {
    IDLE   = 4'b0001,
    SCAN   = 4'b0010,
    DRAIN  = 4'b0100,
    COMMIT = 4'b1000
  } state_t;

  state_t state, state_next;
  logic [CW-1:0] cnt, cnt_next;

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          cnt_next = '0;
          if (action == ffds_pkg::ACT_DATA || action == ffds_pkg::ACT_FORMAT) begin
            state_next = COMMIT;
          end else begin
            state_next = SCAN;
          end
        end
      end
      SCAN: begin
        cmd.issue = 1'b1;
        if (cnt == CW'(DIR_ENTRIES - 1)) begin
          state_next = DRAIN;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      DRAIN: begin
        state_next = COMMIT;
      end
      COMMIT: begin
        if (!out_valid || out_ready) begin
          cmd.commit = 1'b1;
          state_next = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  assign rd_addr = cnt[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("item accepted while busy");

  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("result lost after commit");

  a_issue_range: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> (cnt < CW'(DIR_ENTRIES)))
    else $error("scan address out of range");

endmodule

// ----- rtl/core/ffds_dp.sv -----
module ffds_dp #(
  parameter int DIR_ENTRIES  = 128,
  parameter int PAGE_BYTES   = 256,
  parameter int SECTOR_BYTES = 4096
) (
  input  logic                                             clk,
  input  logic                                             rst,
  input  ffds_pkg::dp_cmd_t                                cmd,
  input  logic [(DIR_ENTRIES > 1 ? $clog2(DIR_ENTRIES) : 1)-1:0] rd_addr,
  input  logic                                             cfg_write,
  input  logic [0:0]                                       cfg_index,
  input  logic [24:0]                                      cfg_data,
  input  logic [2:0]                                       action,
  input  logic [15:0]                                      file_id,
  input  logic [23:0]                                      file_size,
  input  logic [7:0]                                       data_byte,
  output logic [2:0]                                       status,
  output logic [23:0]                                      file_start,
  output logic [23:0]                                      found_size,
  output logic [15:0]                                      crc_value,
  output logic [23:0]                                      flash_addr,
  output logic                                             erase_first,
  output logic                                             page_start,
  output logic [24:0]                                      free_space
);

  localparam int AW = DIR_ENTRIES > 1 ? $clog2(DIR_ENTRIES) : 1;
  localparam int SECT_SH = $clog2(SECTOR_BYTES);
  localparam int PG_SH = $clog2(PAGE_BYTES);
  localparam int SW = 24 - SECT_SH;

  logic [23:0] cfg_start;
  logic [24:0] cfg_size;
  logic [2:0]  it_act;
  logic [15:0] it_id;
  logic [23:0] it_size;
  logic [7:0]  it_byte;

  logic [DIR_ENTRIES-1:0] valid;
  ffds_pkg::entry_t ram_q, ram_d;
  logic          ram_we;

  logic          rd_live, rd_vld;
  logic [AW-1:0] rd_idx;

  logic          m_found, fr_found;
  logic [AW-1:0] m_idx, fr_idx;
  logic [23:0]   m_start, m_size;
  logic [15:0]   m_crc;
  logic [24:0]   max_end;

  logic [15:0]   pend_id;
  logic [23:0]   pend_base, pend_size, done;
  logic          sec_valid;
  logic [SW-1:0] last_sec;
  logic [15:0]   rcrc;

  logic          hit, excl, incl;
  logic [24:0]   ent_end;
  logic [25:0]   re_sum;
  logic [24:0]   region_end;

  logic          over;
  logic [23:0]   cur;
  logic [SW-1:0] sec;
  logic          need_erase;
  logic          pend_ok;
  logic [24:0]   p_end;
  logic [25:0]   n_plus;
  logic          end_ok, start_ok;
  logic [24:0]   nv;

  logic [2:0]    r_status;
  logic [23:0]   r_saddr, r_fsize, r_faddr;
  logic [15:0]   r_crc;
  logic          r_erase, r_pstart;

  ffds_ram #(.WIDTH($bits(ffds_pkg::entry_t)), .DEPTH(DIR_ENTRIES)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(fr_idx),
    .wdata(ram_d),
    .raddr(rd_addr),
    .rdata(ram_q)
  );

  assign re_sum = {2'b00, cfg_start} + {1'b0, cfg_size};
  assign region_end = (re_sum > {1'b0, ffds_pkg::ADDR_LIMIT}) ? ffds_pkg::ADDR_LIMIT
                                                               : re_sum[24:0];

  assign hit = rd_vld && (ram_q.id == it_id) && !m_found;
  assign excl = (it_act == ffds_pkg::ACT_START && it_size != 24'd0) ||
                (it_act == ffds_pkg::ACT_DELETE);
  assign incl = rd_vld && !(hit && excl);
  assign ent_end = {1'b0, ram_q.start} + {1'b0, ram_q.size};

  assign over = ({1'b0, done} + 25'd1) > {1'b0, pend_size};
  assign cur = pend_base + done;
  assign sec = cur[23:SECT_SH];
  assign need_erase = !sec_valid || (sec != last_sec);
  assign pend_ok = (pend_size != 24'd0) && (done == pend_size);
  assign p_end = {1'b0, pend_base} + {1'b0, pend_size};
  assign n_plus = {1'b0, max_end} + {2'b00, it_size};
  assign start_ok = (it_size != 24'd0) && (n_plus <= {1'b0, region_end});
  assign end_ok = pend_ok && fr_found;

  always_comb begin
    r_status = ffds_pkg::ST_OK;
    r_saddr = '0;
    r_fsize = '0;
    r_crc = '0;
    r_faddr = '0;
    r_erase = 1'b0;
    r_pstart = 1'b0;
    nv = max_end;
    case (it_act)
      ffds_pkg::ACT_LOOKUP: begin
        if (m_found) begin
          r_saddr = m_start;
          r_fsize = m_size;
          r_crc = m_crc;
        end else begin
          r_status = ffds_pkg::ST_NOT_FOUND;
        end
      end
      ffds_pkg::ACT_START: begin
        if (it_size == 24'd0) begin
          r_status = ffds_pkg::ST_BAD_SIZE;
        end else begin
          r_saddr = max_end[23:0];
          if (!start_ok) begin
            r_status = ffds_pkg::ST_NO_SPACE;
          end
        end
      end
      ffds_pkg::ACT_DATA: begin
        if (over) begin
          r_status = ffds_pkg::ST_OVERFLOW;
        end else begin
          r_faddr = cur;
          r_erase = need_erase;
          r_pstart = (done == 24'd0) || (cur[PG_SH-1:0] == '0);
        end
      end
      ffds_pkg::ACT_END: begin
        if (!pend_ok) begin
          r_status = ffds_pkg::ST_INCOMPLETE;
        end else if (!fr_found) begin
          r_status = ffds_pkg::ST_DIR_FULL;
        end else begin
          r_crc = rcrc;
          if (p_end > max_end) begin
            nv = p_end;
          end
        end
      end
      ffds_pkg::ACT_DELETE: begin
        if (!m_found) begin
          r_status = ffds_pkg::ST_NOT_FOUND;
        end
      end
      ffds_pkg::ACT_FORMAT: begin
        nv = {1'b0, cfg_start};
      end
      default: begin
      end
    endcase
  end

  assign ram_we = cmd.commit && (it_act == ffds_pkg::ACT_END) && end_ok;
  assign ram_d = '{id: pend_id, start: pend_base, size: pend_size, crc: rcrc};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_start <= ffds_pkg::START_RESET;
      cfg_size <= ffds_pkg::SIZE_RESET;
      valid <= '0;
      rd_live <= 1'b0;
      pend_id <= '0;
      pend_base <= '0;
      pend_size <= '0;
      done <= '0;
      sec_valid <= 1'b0;
      rcrc <= ffds_pkg::CRC_INIT;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          ffds_pkg::CFG_START: cfg_start <= cfg_data[23:0];
          ffds_pkg::CFG_SIZE:  cfg_size <= cfg_data;
          default: begin
          end
        endcase
      end
      rd_live <= cmd.issue;
      if (cmd.commit) begin
        case (it_act)
          ffds_pkg::ACT_START: begin
            if (it_size != 24'd0 && m_found) begin
              valid[m_idx] <= 1'b0;
            end
            if (start_ok) begin
              pend_id <= it_id;
              pend_base <= max_end[23:0];
              pend_size <= it_size;
              done <= '0;
              sec_valid <= 1'b0;
              rcrc <= ffds_pkg::CRC_INIT;
            end
          end
          ffds_pkg::ACT_DATA: begin
            if (!over) begin
              sec_valid <= 1'b1;
              rcrc <= ffds_pkg::crc_byte(rcrc, it_byte);
              done <= done + 24'd1;
            end
          end
          ffds_pkg::ACT_END: begin
            if (end_ok) begin
              valid[fr_idx] <= 1'b1;
              pend_size <= '0;
              done <= '0;
            end
          end
          ffds_pkg::ACT_DELETE: begin
            if (m_found) begin
              valid[m_idx] <= 1'b0;
            end
          end
          ffds_pkg::ACT_FORMAT: begin
            valid <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= rd_addr;
    rd_vld <= valid[rd_addr];
    if (cmd.commit && it_act == ffds_pkg::ACT_DATA && !over && need_erase) begin
      last_sec <= sec;
    end
    if (cmd.accept) begin
      it_act <= action;
      it_id <= file_id;
      it_size <= file_size;
      it_byte <= data_byte;
      m_found <= 1'b0;
      fr_found <= 1'b0;
      max_end <= {1'b0, cfg_start};
    end else if (rd_live) begin
      if (hit) begin
        m_found <= 1'b1;
        m_idx <= rd_idx;
        m_start <= ram_q.start;
        m_size <= ram_q.size;
        m_crc <= ram_q.crc;
      end
      if (incl && ent_end > max_end) begin
        max_end <= ent_end;
      end
      if (!rd_vld && !fr_found) begin
        fr_found <= 1'b1;
        fr_idx <= rd_idx;
      end
    end
    if (cmd.commit) begin
      status <= r_status;
      file_start <= r_saddr;
      found_size <= r_fsize;
      crc_value <= r_crc;
      flash_addr <= r_faddr;
      erase_first <= r_erase;
      page_start <= r_pstart;
      if (it_act == ffds_pkg::ACT_DATA) begin
        free_space <= '0;
      end else if (region_end > nv) begin
        free_space <= region_end - nv;
      end else begin
        free_space <= '0;
      end
    end
  end

  a_start_ok_fits: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && it_act == ffds_pkg::ACT_START && start_ok) |=>
      ({1'b0, pend_base} + {1'b0, pend_size} <= region_end))
    else $error("placed file exceeds the region");

  a_done_bounded: assert property (@(posedge clk) disable iff (rst)
    done <= pend_size)
    else $error("byte count beyond declared size");

  a_end_sets_valid: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> valid[$past(fr_idx)])
    else $error("recorded entry not marked valid");

endmodule

// ----- rtl/core/flash_file_directory_stream.sv -----
// Append-only file directory for a serial flash, one action per item and one result per item.
// Data bytes and format skip the directory sweep: after acceptance they go straight to the commit
// state, whose result is registered. Lookup, start, end, delete and any unused action sweep the
// whole directory memory, one entry per cycle through its single read port, then drain and commit.
// The directory is empty after reset, with no clearing pass. PAGE_BYTES and SECTOR_BYTES must
// be powers of two. The configuration port may be written only while no item is in progress.
module flash_file_directory_stream #(
  parameter int DIR_ENTRIES  = 128,
  parameter int PAGE_BYTES   = 256,
  parameter int SECTOR_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [0:0]  cfg_index,
  input  logic [24:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  action,
  input  logic [15:0] file_id,
  input  logic [23:0] file_size,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [23:0] file_start,
  output logic [23:0] found_size,
  output logic [15:0] crc_value,
  output logic [23:0] flash_addr,
  output logic        erase_first,
  output logic        page_start,
  output logic [24:0] free_space
);

  localparam int AW = DIR_ENTRIES > 1 ? $clog2(DIR_ENTRIES) : 1;

  ffds_pkg::dp_cmd_t cmd;
  logic [AW-1:0]     rd_addr;

  ffds_ctrl #(.DIR_ENTRIES(DIR_ENTRIES)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .action   (action),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd),
    .rd_addr  (rd_addr)
  );

  ffds_dp #(
    .DIR_ENTRIES (DIR_ENTRIES),
    .PAGE_BYTES  (PAGE_BYTES),
    .SECTOR_BYTES(SECTOR_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .rd_addr    (rd_addr),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .action     (action),
    .file_id    (file_id),
    .file_size  (file_size),
    .data_byte  (data_byte),
    .status     (status),
    .file_start (file_start),
    .found_size (found_size),
    .crc_value  (crc_value),
    .flash_addr (flash_addr),
    .erase_first(erase_first),
    .page_start (page_start),
    .free_space (free_space)
  );

endmodule

// ----- dv/flash_file_directory_stream_check.sv -----
module flash_file_directory_stream_check #(
  parameter int DIR_ENTRIES  = 128,
  parameter int PAGE_BYTES   = 256,
  parameter int SECTOR_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [0:0]  cfg_index,
  input  logic [24:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  action,
  input  logic [15:0] file_id,
  input  logic [23:0] file_size,
  input  logic [7:0]  data_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  status,
  input  logic [23:0] file_start,
  input  logic [23:0] found_size,
  input  logic [15:0] crc_value,
  input  logic [23:0] flash_addr,
  input  logic        erase_first,
  input  logic        page_start,
  input  logic [24:0] free_space,
  output int          errors,
  output int          waiting
);

  localparam int unsigned NO_SECTOR = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [2:0]  status;
    logic [23:0] file_start;
    logic [23:0] found_size;
    logic [15:0] crc_value;
    logic [23:0] flash_addr;
    logic        erase_first;
    logic        page_start;
    logic [24:0] free_space;
  } dir_result_t;

  dir_result_t due_results[$];

  int unsigned region_base;
  int unsigned region_len;
  bit          slot_used[DIR_ENTRIES];
  logic [15:0] slot_id[DIR_ENTRIES];
  int unsigned slot_start[DIR_ENTRIES];
  int unsigned slot_size[DIR_ENTRIES];
  logic [15:0] slot_crc[DIR_ENTRIES];
  logic [15:0] open_id;
  int unsigned open_base;
  int unsigned open_size;
  int unsigned open_count;
  int unsigned erased_sector;
  logic [15:0] open_crc;

  function automatic int unsigned region_limit();
    int unsigned e;
    e = region_base + region_len;
    return (e > 32'h100_0000) ? 32'h100_0000 : e;
  endfunction

  function automatic int unsigned append_point();
    int unsigned n;
    n = region_base;
    for (int i = 0; i < DIR_ENTRIES; i++) begin
      if (slot_used[i] && slot_start[i] + slot_size[i] > n) begin
        n = slot_start[i] + slot_size[i];
      end
    end
    return n;
  endfunction

  function automatic int unsigned room_left();
    int unsigned e;
    int unsigned n;
    e = region_limit();
    n = append_point();
    return (e > n) ? e - n : 0;
  endfunction

  function automatic int slot_of(logic [15:0] id);
    for (int i = 0; i < DIR_ENTRIES; i++) begin
      if (slot_used[i] && slot_id[i] == id) return i;
    end
    return -1;
  endfunction

  function automatic logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      r = r[15] ? ({r[14:0], 1'b0} ^ 16'h1021) : {r[14:0], 1'b0};
    end
    return r;
  endfunction

  task automatic directory_step(input logic [2:0] a, input logic [15:0] id,
                                input logic [23:0] sz, input logic [7:0] b,
                                output dir_result_t r);
    int i;
    int free_slot;
    int unsigned n;
    int unsigned cur;
    r = '0;
    case (a)
      ffds_pkg::ACT_LOOKUP: begin
        i = slot_of(id);
        if (i < 0) begin
          r.status = ffds_pkg::ST_NOT_FOUND;
        end else begin
          r.file_start = slot_start[i][23:0];
          r.found_size = slot_size[i][23:0];
          r.crc_value = slot_crc[i];
        end
        r.free_space = 25'(room_left());
      end
      ffds_pkg::ACT_START: begin
        if (sz == 0) begin
          r.status = ffds_pkg::ST_BAD_SIZE;
        end else begin
          i = slot_of(id);
          if (i >= 0) slot_used[i] = 0;
          n = append_point();
          r.file_start = n[23:0];
          if (n + {8'h00, sz} > region_limit()) begin
            r.status = ffds_pkg::ST_NO_SPACE;
          end else begin
            open_id = id;
            open_base = n;
            open_size = {8'h00, sz};
            open_count = 0;
            erased_sector = NO_SECTOR;
            open_crc = 16'hFFFF;
          end
        end
        r.free_space = 25'(room_left());
      end
      ffds_pkg::ACT_DATA: begin
        if (open_count + 1 > open_size) begin
          r.status = ffds_pkg::ST_OVERFLOW;
        end else begin
          cur = (open_base + open_count) & 32'hFF_FFFF;
          r.flash_addr = cur[23:0];
          if (cur / SECTOR_BYTES != erased_sector) begin
            r.erase_first = 1'b1;
            erased_sector = cur / SECTOR_BYTES;
          end
          r.page_start = (open_count == 0 || cur % PAGE_BYTES == 0);
          open_crc = crc_step(open_crc, b);
          open_count++;
        end
      end
      ffds_pkg::ACT_END: begin
        if (open_size == 0 || open_count != open_size) begin
          r.status = ffds_pkg::ST_INCOMPLETE;
        end else begin
          free_slot = -1;
          for (int k = 0; k < DIR_ENTRIES; k++) begin
            if (!slot_used[k] && free_slot < 0) free_slot = k;
          end
          if (free_slot < 0) begin
            r.status = ffds_pkg::ST_DIR_FULL;
          end else begin
            slot_used[free_slot] = 1;
            slot_id[free_slot] = open_id;
            slot_start[free_slot] = open_base;
            slot_size[free_slot] = open_size;
            slot_crc[free_slot] = open_crc;
            r.crc_value = open_crc;
            open_size = 0;
            open_count = 0;
          end
        end
        r.free_space = 25'(room_left());
      end
      ffds_pkg::ACT_DELETE: begin
        i = slot_of(id);
        if (i < 0) r.status = ffds_pkg::ST_NOT_FOUND;
        else slot_used[i] = 0;
        r.free_space = 25'(room_left());
      end
      ffds_pkg::ACT_FORMAT: begin
        for (int k = 0; k < DIR_ENTRIES; k++) slot_used[k] = 0;
        r.free_space = 25'(room_left());
      end
      default: begin
        r.free_space = 25'(room_left());
      end
    endcase
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    dir_result_t r;
    if (rst) begin
      errors = 0;
      due_results.delete();
      region_base = {8'h00, ffds_pkg::START_RESET};
      region_len = {7'h00, ffds_pkg::SIZE_RESET};
      for (int k = 0; k < DIR_ENTRIES; k++) slot_used[k] = 0;
      open_id = 0;
      open_base = 0;
      open_size = 0;
      open_count = 0;
      erased_sector = NO_SECTOR;
      open_crc = 16'hFFFF;
    end else begin
      if (cfg_write) begin
        if (cfg_index == ffds_pkg::CFG_START) region_base = {8'h00, cfg_data[23:0]};
        else region_len = {7'h00, cfg_data};
      end
      if (in_valid && in_ready) begin
        directory_step(action, file_id, file_size, data_byte, r);
        due_results.push_back(r);
      end
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          report("result with no item due", status, 0);
        end else begin
          r = due_results.pop_front();
          if (status !== r.status) report("status", status, r.status);
          if (file_start !== r.file_start) report("file_start", file_start, r.file_start);
          if (found_size !== r.found_size) report("found_size", found_size, r.found_size);
          if (crc_value !== r.crc_value) report("crc_value", crc_value, r.crc_value);
          if (flash_addr !== r.flash_addr) report("flash_addr", flash_addr, r.flash_addr);
          if (erase_first !== r.erase_first) report("erase_first", erase_first, r.erase_first);
          if (page_start !== r.page_start) report("page_start", page_start, r.page_start);
          if (free_space !== r.free_space) report("free_space", free_space, r.free_space);
        end
      end
    end
    waiting = due_results.size();
  end

endmodule

// ----- dv/flash_file_directory_stream_test.sv -----
module flash_file_directory_stream_test;

  localparam logic [2:0] ACT_SPARE_LO = 3'd6;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;
  localparam int DIR_ENTRIES_TB = 129;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [0:0]  cfg_index;
  logic [24:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  action;
  logic [15:0] file_id;
  logic [23:0] file_size;
  logic [7:0]  data_byte;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  status;
  logic [23:0] file_start;
  logic [23:0] found_size;
  logic [15:0] crc_value;
  logic [23:0] flash_addr;
  logic        erase_first;
  logic        page_start;
  logic [24:0] free_space;
  int          errors;
  int          waiting;
  int          items_sent;
  int          files_streamed;
  bit          quiet;

  flash_file_directory_stream dut (.*);

  flash_file_directory_stream_check checker_i (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("flash_file_directory_stream_test: errors");
    $finish;
  end

  initial begin
    out_ready = 0;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(4) == 0) begin
        out_ready <= 0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      out_ready <= 1;
    end
  end

  task automatic send_item(input logic [2:0] a, input logic [15:0] id,
                           input logic [23:0] sz, input logic [7:0] b);
    if (!quiet && $urandom_range(3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1;
    action <= a;
    file_id <= id;
    file_size <= sz;
    data_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic stream_file(input logic [15:0] id, input int unsigned sz, input int skew);
    send_item(ffds_pkg::ACT_START, id, 24'(sz), 8'($urandom));
    for (int k = 0; k < int'(sz) + skew; k++) begin
      send_item(ffds_pkg::ACT_DATA, 16'($urandom), 24'($urandom), 8'($urandom));
    end
    send_item(ffds_pkg::ACT_END, id, 24'($urandom), 8'($urandom));
    files_streamed++;
  endtask

  task automatic settle_and_configure(input logic [23:0] base, input logic [24:0] len);
    in_valid <= 0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_write <= 1;
    cfg_index <= ffds_pkg::CFG_START;
    cfg_data <= {1'b0, base};
    @(posedge clk);
    cfg_index <= ffds_pkg::CFG_SIZE;
    cfg_data <= len;
    @(posedge clk);
    cfg_write <= 0;
  endtask

  task automatic random_phase(input int count);
    int p;
    int unsigned sz;
    int skew;
    int stop;
    stop = items_sent + count;
    while (items_sent < stop) begin
      p = $urandom_range(99);
      if (p < 60) begin
        p = $urandom_range(99);
        sz = (p < 80) ? $urandom_range(1, 24) : (p < 95) ? $urandom_range(25, 300) : 0;
        skew = ($urandom_range(9) == 0) ? $urandom_range(0, 2) - 1 : 0;
        if (sz == 0) begin
          send_item(ffds_pkg::ACT_START, 16'($urandom_range(15)), 24'($urandom),
                    8'($urandom));
          repeat ($urandom_range(0, 3)) begin
            send_item(ffds_pkg::ACT_DATA, 16'($urandom), 24'($urandom), 8'($urandom));
          end
          send_item(ffds_pkg::ACT_END, 16'($urandom), 24'($urandom), 8'($urandom));
        end else begin
          stream_file(16'($urandom_range(15)), sz, skew);
        end
      end else if (p < 70) begin
        send_item(ffds_pkg::ACT_LOOKUP, 16'($urandom_range(15)), 24'($urandom),
                  8'($urandom));
      end else if (p < 78) begin
        send_item(ffds_pkg::ACT_DELETE, 16'($urandom_range(15)), 24'($urandom),
                  8'($urandom));
      end else if (p < 80) begin
        send_item(ffds_pkg::ACT_FORMAT, 16'($urandom), 24'($urandom), 8'($urandom));
      end else if (p < 83) begin
        send_item(p[0] ? ACT_SPARE_LO : ACT_SPARE_HI, 16'($urandom), 24'($urandom),
                  8'($urandom));
      end else begin
        send_item(3'($urandom_range(7)), 16'($urandom), 24'($urandom), 8'($urandom));
      end
    end
  endtask

  initial begin
    rst = 1;
    quiet = 0;
    items_sent = 0;
    files_streamed = 0;
    cfg_write = 0;
    cfg_index = ffds_pkg::CFG_START;
    cfg_data = 0;
    in_valid = 0;
    action = ffds_pkg::ACT_LOOKUP;
    file_id = 0;
    file_size = 0;
    data_byte = 0;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send_item(ffds_pkg::ACT_LOOKUP, 16'hFFFF, 0, 0);
    send_item(ffds_pkg::ACT_START, 16'h1234, 0, 0);
    send_item(ffds_pkg::ACT_DATA, 0, 0, 8'hFF);
    send_item(ffds_pkg::ACT_END, 0, 0, 0);
    send_item(ffds_pkg::ACT_START, 16'hFFFF, 3, 0);
    send_item(ffds_pkg::ACT_DATA, 0, 0, 8'h00);
    send_item(ffds_pkg::ACT_DATA, 0, 0, 8'hFF);
    send_item(ffds_pkg::ACT_DATA, 0, 0, 8'hA5);
    send_item(ffds_pkg::ACT_DATA, 0, 0, 8'h5A);
    send_item(ffds_pkg::ACT_END, 0, 0, 0);
    send_item(ffds_pkg::ACT_LOOKUP, 16'hFFFF, 0, 0);
    send_item(ffds_pkg::ACT_START, 16'hFFFF, 2, 0);
    send_item(ffds_pkg::ACT_DATA, 0, 0, 8'h01);
    send_item(ffds_pkg::ACT_END, 0, 0, 0);
    send_item(ffds_pkg::ACT_DATA, 0, 0, 8'h80);
    send_item(ffds_pkg::ACT_END, 0, 0, 0);
    send_item(ffds_pkg::ACT_DELETE, 16'hFFFF, 0, 0);
    send_item(ffds_pkg::ACT_DELETE, 16'hFFFF, 0, 0);
    send_item(ffds_pkg::ACT_START, 16'h0000, 24'hFFFFFF, 0);
    send_item(ACT_SPARE_LO, 0, 0, 0);
    send_item(ACT_SPARE_HI, 16'hFFFF, 24'hFFFFFF, 8'hFF);
    send_item(ffds_pkg::ACT_FORMAT, 0, 0, 0);
    stream_file(16'h0000, 1, 0);

    random_phase(230);
    settle_and_configure(24'h000000, 25'h1000000);
    random_phase(200);
    settle_and_configure(24'hFFFFF0, 25'h1FFFFFF);
    random_phase(120);
    settle_and_configure(24'd4090, 25'd300);
    send_item(ffds_pkg::ACT_FORMAT, 0, 0, 0);
    random_phase(150);
    settle_and_configure(24'd1000, 25'd0);
    random_phase(60);
    settle_and_configure(24'h7FF0F0, 25'h100000);
    random_phase(200);

    settle_and_configure(ffds_pkg::START_RESET, ffds_pkg::SIZE_RESET);
    send_item(ffds_pkg::ACT_FORMAT, 0, 0, 0);
    for (int k = 0; k < DIR_ENTRIES_TB; k++) stream_file(16'(16'h0100 + k), 1, 0);
    send_item(ffds_pkg::ACT_END, 0, 0, 0);
    send_item(ffds_pkg::ACT_DELETE, 16'h0103, 0, 0);
    send_item(ffds_pkg::ACT_END, 0, 0, 0);
    send_item(ffds_pkg::ACT_LOOKUP, 16'(16'h0100 + DIR_ENTRIES_TB - 1), 0, 0);

    quiet = 1;
    settle_and_configure(24'($urandom), 25'($urandom_range(0, 24'hFFFFFF)));
    random_phase(150);

    in_valid <= 0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    $display("Sent %0d items, %0d file streams, across seven region settings,", items_sent,
             files_streamed);
    $display("including a completely filled directory and retried file closes.");
    if (errors == 0 && waiting == 0) begin
      $display("flash_file_directory_stream_test: clean");
    end else begin
      $display("flash_file_directory_stream_test: errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/ffds_pkg.sv
rtl/core/ffds_ram.sv
rtl/core/ffds_ctrl.sv
rtl/core/ffds_dp.sv
rtl/core/flash_file_directory_stream.sv
dv/flash_file_directory_stream_check.sv
dv/flash_file_directory_stream_test.sv
